// File: src/tcce_pkg.sv
package tcce_pkg;

	// Default screen geometry
	localparam int DEF_SCREEN_COLS = 80;
	localparam int DEF_SCREEN_ROWS = 25;

	// Control characters and blank cell contents
	localparam logic [7:0] CH_BACKSPACE = 8'd8;
	localparam logic [7:0] CH_NEWLINE   = 8'd10;
	localparam logic [7:0] CH_RETURN    = 8'd13;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] RESET_ATTR   = 8'h07;

	// Item kinds; the fourth code is ignored
	typedef enum logic [1:0] {
		KIND_PUT   = 2'd0,
		KIND_CLEAR = 2'd1,
		KIND_READ  = 2'd2
	} kind_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] char_code;
		logic [4:0] read_row;
		logic [6:0] read_col;
	} item_t;

	typedef struct packed {
		logic [4:0] cursor_row;
		logic [6:0] cursor_col;
		logic [7:0] cell_char;
		logic [7:0] cell_attr;
	} res_t;

endpackage

// File: src/text_console_cursor_engine_top.sv
// Put, return, newline, backspace and an unused kind pass through decode and done states;
// a read in range adds a wait for the registered memory port; a clear blanks every cell in
// a fill state. A put or newline that scrolls copies each cell up through the single memory
// port pair in a read state then a write state, then blanks the bottom row one cell a cycle.
// One item at a time; in_stall is high while an item is in progress.
// After reset the store is swept to blank cells with in_stall high.
module text_console_cursor_engine_top #(
	parameter int SCREEN_COLS = tcce_pkg::DEF_SCREEN_COLS,
	parameter int SCREEN_ROWS = tcce_pkg::DEF_SCREEN_ROWS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] kind,
	input  logic [7:0] char_code,
	input  logic [4:0] read_row,
	input  logic [6:0] read_col,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [4:0] cursor_row,
	output logic [6:0] cursor_col,
	output logic [7:0] cell_char,
	output logic [7:0] cell_attr
);

	import tcce_pkg::*;

	localparam int ADDR_W = $clog2(SCREEN_ROWS * SCREEN_COLS);

	logic              busy;
	logic              in_take;
	logic              res_valid;
	logic              res_ready;
	item_t             item;
	res_t              res;
	res_t              out_q;
	logic              out_valid_q;
	logic [7:0]        text_attribute_q;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [15:0]       mem_wdata;
	logic              mem_re;
	logic [ADDR_W-1:0] mem_raddr;
	logic [15:0]       mem_rdata;

	// Attribute register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_attribute_q <= RESET_ATTR;
		end else if (cfg_wr_en) begin
			text_attribute_q <= cfg_wr_data;
		end
	end

	// Input beat
	assign in_stall = busy;
	assign in_take  = in_valid && !busy;

	always_comb begin
		item.kind      = kind;
		item.char_code = char_code;
		item.read_row  = read_row;
		item.read_col  = read_col;
	end

	// Output register: load when empty or being drained
	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign cursor_row = out_q.cursor_row;
	assign cursor_col = out_q.cursor_col;
	assign cell_char  = out_q.cell_char;
	assign cell_attr  = out_q.cell_attr;

	tcce_ctrl #(
		.SCREEN_COLS(SCREEN_COLS),
		.SCREEN_ROWS(SCREEN_ROWS)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_take       (in_take),
		.item          (item),
		.text_attribute(text_attribute_q),
		.res_ready     (res_ready),
		.busy          (busy),
		.res_valid     (res_valid),
		.res           (res),
		.mem_we        (mem_we),
		.mem_waddr     (mem_waddr),
		.mem_wdata     (mem_wdata),
		.mem_re        (mem_re),
		.mem_raddr     (mem_raddr),
		.mem_rdata     (mem_rdata)
	);

	tcce_ram #(
		.DEPTH(SCREEN_ROWS * SCREEN_COLS)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

endmodule

// File: src/tcce_ram.sv
module tcce_ram #(
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [15:0]              wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [15:0]              rdata
);

	logic [15:0] mem_q [DEPTH];
	logic [15:0] rdata_q;

	// One write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// One registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: src/tcce_ctrl.sv
module tcce_ctrl #(
	parameter int SCREEN_COLS = 80,
	parameter int SCREEN_ROWS = 25
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       in_take,
	input  tcce_pkg::item_t                            item,
	input  logic [7:0]                                 text_attribute,
	input  logic                                       res_ready,
	output logic                                       busy,
	output logic                                       res_valid,
	output tcce_pkg::res_t                             res,
	output logic                                       mem_we,
	output logic [$clog2(SCREEN_ROWS*SCREEN_COLS)-1:0] mem_waddr,
	output logic [15:0]                                mem_wdata,
	output logic                                       mem_re,
	output logic [$clog2(SCREEN_ROWS*SCREEN_COLS)-1:0] mem_raddr,
	input  logic [15:0]                                mem_rdata
);

	import tcce_pkg::*;

	localparam int CELLS  = SCREEN_ROWS * SCREEN_COLS;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int ROW_W  = $clog2(SCREEN_ROWS);
	localparam int COL_W  = $clog2(SCREEN_COLS);

	localparam logic [ADDR_W-1:0] LAST_CELL   = ADDR_W'(CELLS - 1);
	localparam logic [ADDR_W-1:0] SCROLL_LAST = ADDR_W'((SCREEN_ROWS - 1) * SCREEN_COLS - 1);
	localparam logic [ADDR_W-1:0] ROW_STRIDE  = ADDR_W'(SCREEN_COLS);
	localparam logic [ROW_W-1:0]  LAST_ROW    = ROW_W'(SCREEN_ROWS - 1);
	localparam logic [COL_W-1:0]  LAST_COL    = COL_W'(SCREEN_COLS - 1);

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_DECODE,
		ST_SCR_RD,
		ST_SCR_WR,
		ST_FILL,
		ST_RD_WAIT,
		ST_DONE
	} state_t;

	state_t            state_q;
	item_t             item_q;
	logic [ROW_W-1:0]  cur_row_q;
	logic [COL_W-1:0]  cur_col_q;
	logic [ADDR_W-1:0] cnt_q;
	logic [7:0]        cell_char_q;
	logic [7:0]        cell_attr_q;

	logic [ADDR_W-1:0] cur_addr;
	logic [ADDR_W-1:0] rd_addr;
	logic              rd_in_range;
	logic              is_ctrl_char;
	logic              row_wrap;

	// Cell address of the cursor and of the requested read
	assign cur_addr = ADDR_W'(cur_row_q) * ROW_STRIDE + ADDR_W'(cur_col_q);
	assign rd_addr  = ADDR_W'(item_q.read_row) * ROW_STRIDE + ADDR_W'(item_q.read_col);

	assign rd_in_range = (32'(item_q.read_row) < 32'(SCREEN_ROWS))
		&& (32'(item_q.read_col) < 32'(SCREEN_COLS));
	assign is_ctrl_char = (item_q.char_code == CH_NEWLINE) || (item_q.char_code == CH_RETURN)
		|| (item_q.char_code == CH_BACKSPACE);
	// Newline, or a printable character at the last column, moves to the next row
	assign row_wrap = (item_q.char_code == CH_NEWLINE)
		|| (!is_ctrl_char && (cur_col_q == LAST_COL));

	// Drive the memory ports from the sequencer state
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cnt_q;
		mem_wdata = {text_attribute, CH_SPACE};
		mem_re    = 1'b0;
		mem_raddr = cnt_q + ROW_STRIDE;
		unique case (state_q)
			ST_INIT: begin
				mem_we    = 1'b1;
				mem_wdata = {RESET_ATTR, CH_SPACE};
			end
			ST_FILL: begin
				mem_we = 1'b1;
			end
			ST_DECODE: begin
				if (item_q.kind == KIND_PUT) begin
					if (item_q.char_code == CH_BACKSPACE) begin
						mem_we    = (cur_col_q != '0);
						mem_waddr = cur_addr - ADDR_W'(1);
					end else if (!is_ctrl_char) begin
						mem_we    = 1'b1;
						mem_waddr = cur_addr;
						mem_wdata = {text_attribute, item_q.char_code};
					end
				end else if (item_q.kind == KIND_READ) begin
					mem_re    = rd_in_range;
					mem_raddr = rd_addr;
				end
			end
			ST_SCR_RD: begin
				mem_re = 1'b1;
			end
			ST_SCR_WR: begin
				mem_we    = 1'b1;
				mem_wdata = mem_rdata;
			end
			default: begin
			end
		endcase
	end

	// Sequencer, cursor and result fields
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			item_q      <= '0;
			cnt_q       <= '0;
			cur_row_q   <= '0;
			cur_col_q   <= '0;
			cell_char_q <= '0;
			cell_attr_q <= '0;
		end else begin
			unique case (state_q)
				ST_INIT: begin
					if (cnt_q == LAST_CELL) begin
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + ADDR_W'(1);
					end
				end
				ST_IDLE: begin
					if (in_take) begin
						item_q      <= item;
						cell_char_q <= '0;
						cell_attr_q <= '0;
						state_q     <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					state_q <= ST_DONE;
					unique case (item_q.kind)
						KIND_PUT: begin
							if (item_q.char_code == CH_RETURN) begin
								cur_col_q <= '0;
							end else if (item_q.char_code == CH_BACKSPACE) begin
								if (cur_col_q != '0) begin
									cur_col_q <= cur_col_q - COL_W'(1);
								end
							end else if (row_wrap) begin
								cur_col_q <= '0;
								if (cur_row_q == LAST_ROW) begin
									cnt_q   <= '0;
									state_q <= ST_SCR_RD;
								end else begin
									cur_row_q <= cur_row_q + ROW_W'(1);
								end
							end else begin
								cur_col_q <= cur_col_q + COL_W'(1);
							end
						end
						KIND_CLEAR: begin
							cur_row_q <= '0;
							cur_col_q <= '0;
							cnt_q     <= '0;
							state_q   <= ST_FILL;
						end
						KIND_READ: begin
							if (rd_in_range) begin
								state_q <= ST_RD_WAIT;
							end
						end
						default: begin
						end
					endcase
				end
				ST_SCR_RD: begin
					state_q <= ST_SCR_WR;
				end
				ST_SCR_WR: begin
					// Advance the copy; the bottom row follows as a blank fill
					cnt_q <= cnt_q + ADDR_W'(1);
					if (cnt_q == SCROLL_LAST) begin
						state_q <= ST_FILL;
					end else begin
						state_q <= ST_SCR_RD;
					end
				end
				ST_FILL: begin
					if (cnt_q == LAST_CELL) begin
						state_q <= ST_DONE;
					end else begin
						cnt_q <= cnt_q + ADDR_W'(1);
					end
				end
				ST_RD_WAIT: begin
					cell_char_q <= mem_rdata[7:0];
					cell_attr_q <= mem_rdata[15:8];
					state_q     <= ST_DONE;
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign res_valid = (state_q == ST_DONE);

	always_comb begin
		res.cursor_row = 5'(cur_row_q);
		res.cursor_col = 7'(cur_col_q);
		res.cell_char  = cell_char_q;
		res.cell_attr  = cell_attr_q;
	end

endmodule
